// ===== sv/sound_dma_fifo_pair_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SOUND_DMA_FIFO_PAIR_DEFINES_SVH
`define SOUND_DMA_FIFO_PAIR_DEFINES_SVH

// Concurrent check, off while reset is asserted.
`define SDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sound_dma_fifo_pair check failed");

// Concurrent check that also runs through reset.
`define SDF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sound_dma_fifo_pair check failed");

`endif

// ===== sv/sdf_pkg.sv =====
// ---------------------------------------------------------------------------
// sdf_pkg
// Shared constants, codes and structs of the sound DMA FIFO pair.
// ---------------------------------------------------------------------------
package sdf_pkg;

    localparam int FIFO_WORDS = 8;
    localparam int NCHAN      = 2;
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int PTR_W      = $clog2(FIFO_WORDS);
    localparam int CNT_W      = $clog2(FIFO_WORDS + 1);
    localparam int SUM_W      = PTR_W + 1;
    localparam int BL_W       = 3;
    localparam int PLAY_BYTES = 4;
    localparam int LOW_WATER  = 3;
    localparam int KIND_W     = 2;
    localparam int TIMER_W    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int CH_A = 0;
    localparam int CH_B = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ENABLE = 2'd0,
        CFG_B_ENABLE = 2'd1,
        CFG_A_TIMER  = 2'd2,
        CFG_B_TIMER  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              push;
        logic              clear;
        logic              tick;
        logic [WORD_W-1:0] word;
    } t_chan_cmd;

    typedef struct packed {
        logic              req;
        logic              dropped;
        logic [BYTE_W-1:0] sample;
        logic              sample_valid;
    } t_chan_stat;

endpackage

// ===== sv/sdf_if.sv =====
// ---------------------------------------------------------------------------
// sdf_in_if / sdf_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface sdf_in_if import sdf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               channel;
    logic [TIMER_W-1:0] timer_index;
    logic [WORD_W-1:0]  word_value;

    modport source (output valid, kind, channel, timer_index, word_value, input ready);
    modport sink   (input valid, kind, channel, timer_index, word_value, output ready);
endinterface

interface sdf_out_if import sdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              dma_request_a;
    logic              dma_request_b;
    logic [BYTE_W-1:0] sample_a;
    logic              sample_a_valid;
    logic [BYTE_W-1:0] sample_b;
    logic              sample_b_valid;
    logic              write_dropped;

    modport source (output valid, dma_request_a, dma_request_b, sample_a, sample_a_valid,
                    sample_b, sample_b_valid, write_dropped, input ready);
    modport sink   (input valid, dma_request_a, dma_request_b, sample_a, sample_a_valid,
                    sample_b, sample_b_valid, write_dropped, output ready);
endinterface

// ===== sv/sdf_chan.sv =====
// ---------------------------------------------------------------------------
// sdf_chan
// One channel: word FIFO, read pointer, count and four-byte play buffer.
// ---------------------------------------------------------------------------
module sdf_chan
    import sdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_cmd  i_cmd,
    output t_chan_stat o_stat
);

    logic [WORD_W-1:0] r_store [FIFO_WORDS];
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [WORD_W-1:0] r_pw, n_pw;
    logic [BL_W-1:0]   r_bl, n_bl;

    logic              full;
    logic              wr_en;
    logic [SUM_W-1:0]  slot_sum;
    logic [PTR_W-1:0]  slot;
    logic [WORD_W-1:0] pw_mid;
    logic [BL_W-1:0]   bl_mid;

    assign full     = r_count >= CNT_W'(FIFO_WORDS);
    assign slot_sum = SUM_W'(r_rp) + SUM_W'(r_count);
    assign slot     = (slot_sum >= SUM_W'(FIFO_WORDS))
                    ? PTR_W'(slot_sum - SUM_W'(FIFO_WORDS)) : PTR_W'(slot_sum);

    always_comb begin
        n_rp    = r_rp;
        n_count = r_count;
        n_pw    = r_pw;
        n_bl    = r_bl;
        wr_en   = 1'b0;
        pw_mid  = r_pw;
        bl_mid  = r_bl;
        o_stat.req     = 1'b0;
        o_stat.dropped = 1'b0;

        if (i_cmd.push) begin
            o_stat.dropped = full;
            if (!full) begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end

        if (i_cmd.clear) begin
            n_count = '0;
        end

        if (i_cmd.tick) begin
            o_stat.req = r_count <= CNT_W'(LOW_WATER);
            // drop the current byte
            if (r_bl != '0) begin
                pw_mid = r_pw >> BYTE_W;
                bl_mid = r_bl - BL_W'(1);
            end
            n_pw = pw_mid;
            n_bl = bl_mid;
            // refill from the FIFO head once the buffer runs dry
            if (bl_mid == '0 && r_count != '0) begin
                n_pw    = r_store[r_rp];
                n_bl    = BL_W'(PLAY_BYTES);
                n_rp    = (r_rp == PTR_W'(FIFO_WORDS - 1)) ? '0 : r_rp + PTR_W'(1);
                n_count = r_count - CNT_W'(1);
            end
        end

        o_stat.sample_valid = n_bl != '0;
        o_stat.sample       = (n_bl != '0) ? n_pw[BYTE_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_count <= '0;
            r_pw    <= '0;
            r_bl    <= '0;
        end else begin
            r_rp    <= n_rp;
            r_count <= n_count;
            r_pw    <= n_pw;
            r_bl    <= n_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[slot] <= i_cmd.word;
        end
    end

endmodule

// ===== sv/sound_dma_fifo_pair.sv =====
// ---------------------------------------------------------------------------
// sound_dma_fifo_pair
// Two audio DMA channels, each a word FIFO feeding a four-byte play buffer.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle and returns one result per item; an item
// passes the input register, then the result register. Each item is
// handled by a single read-modify-write of the channel registers between those
// two registers, so the rate is one item per cycle whenever the result side
// keeps taking transfers; the result register is the only thing that stalls
// the input. Word writes go to the FIFO of the selected channel, or are
// dropped and flagged when it is full. A timer overflow ticks every enabled
// channel whose timer select matches: it raises a DMA request at three words
// or fewer, drops the current byte and unpacks the next word low byte first
// when the play buffer is empty. Configuration writes take effect at once and
// are meant to be issued only while the block is idle.
// ---------------------------------------------------------------------------
module sound_dma_fifo_pair
    import sdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdf_in_if.sink               i_in,
    sdf_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data
);

    // configuration registers
    logic [NCHAN-1:0] r_enable;
    logic [NCHAN-1:0] r_timer_sel;

    // input register
    logic               r_s1_valid;
    logic [KIND_W-1:0]  r_s1_kind;
    logic               r_s1_channel;
    logic [TIMER_W-1:0] r_s1_timer;
    logic [WORD_W-1:0]  r_s1_word;

    // result register
    logic              r_out_valid;
    t_chan_stat        r_out_stat [NCHAN];

    logic              in_xfer;
    logic              out_adv;
    logic              s1_move;
    t_chan_cmd         cmd  [NCHAN];
    t_chan_stat        stat [NCHAN];

    // the result slot frees up when empty or when its transfer completes
    assign out_adv     = !r_out_valid || o_out.ready;
    assign s1_move     = r_s1_valid && out_adv;
    assign i_in.ready  = !r_s1_valid || out_adv;
    assign in_xfer     = i_in.valid && i_in.ready;

    // decode the held item into per-channel commands
    always_comb begin
        for (int ch = 0; ch < NCHAN; ch++) begin
            cmd[ch].push  = 1'b0;
            cmd[ch].clear = 1'b0;
            cmd[ch].tick  = 1'b0;
            cmd[ch].word  = r_s1_word;
        end
        if (s1_move) begin
            unique case (r_s1_kind)
                KIND_WRITE: begin
                    cmd[r_s1_channel].push = 1'b1;
                end
                KIND_CLEAR: begin
                    cmd[r_s1_channel].clear = 1'b1;
                end
                KIND_TICK: begin
                    // timers two and three never match a one-bit select
                    for (int ch = 0; ch < NCHAN; ch++) begin
                        cmd[ch].tick = r_enable[ch]
                                     && (r_s1_timer == TIMER_W'(r_timer_sel[ch]));
                    end
                end
                default: begin
                    // unknown kind: leave the channels alone
                end
            endcase
        end
    end

    for (genvar g = 0; g < NCHAN; g++) begin : g_chan
        sdf_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[g]),
            .o_stat  (stat[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= '0;
            r_timer_sel <= '0;
        end else begin
            // hold the input register until the result slot can take it
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_A_ENABLE: r_enable[CH_A]    <= i_cfg_data;
                    CFG_B_ENABLE: r_enable[CH_B]    <= i_cfg_data;
                    CFG_A_TIMER:  r_timer_sel[CH_A] <= i_cfg_data;
                    CFG_B_TIMER:  r_timer_sel[CH_B] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_kind    <= i_in.kind;
            r_s1_channel <= i_in.channel;
            r_s1_timer   <= i_in.timer_index;
            r_s1_word    <= i_in.word_value;
        end
        if (s1_move) begin
            for (int ch = 0; ch < NCHAN; ch++) begin
                r_out_stat[ch] <= stat[ch];
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.dma_request_a  = r_out_stat[CH_A].req;
    assign o_out.dma_request_b  = r_out_stat[CH_B].req;
    assign o_out.sample_a       = r_out_stat[CH_A].sample;
    assign o_out.sample_a_valid = r_out_stat[CH_A].sample_valid;
    assign o_out.sample_b       = r_out_stat[CH_B].sample;
    assign o_out.sample_b_valid = r_out_stat[CH_B].sample_valid;
    assign o_out.write_dropped  = r_out_stat[CH_A].dropped | r_out_stat[CH_B].dropped;

endmodule

// ===== sv/sdf_checker.sv =====
// ---------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the sound DMA FIFO pair, bound to the top level.
// ---------------------------------------------------------------------------
`include "sound_dma_fifo_pair_defines.svh"

module sdf_checker
    import sdf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_dma_request_a,
    input logic              i_dma_request_b,
    input logic [BYTE_W-1:0] i_sample_a,
    input logic              i_sample_a_valid,
    input logic [BYTE_W-1:0] i_sample_b,
    input logic              i_sample_b_valid,
    input logic              i_write_dropped
);

    logic any_req;

    assign any_req = i_dma_request_a || i_dma_request_b;

    // a stalled result stays offered
    `SDF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // a drop flag comes from a write, a request from a tick: never both
    `SDF_ASSERT(a_flag_excl, i_clk, i_rst_n, i_out_valid |-> !(i_write_dropped && any_req))

    // an empty play buffer shows a zero byte
    `SDF_ASSERT(a_empty_a, i_clk, i_rst_n, i_out_valid && !i_sample_a_valid |-> i_sample_a == '0)

    `SDF_ASSERT(a_empty_b, i_clk, i_rst_n, i_out_valid && !i_sample_b_valid |-> i_sample_b == '0)

    // nothing is offered right after reset
    `SDF_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind sound_dma_fifo_pair sdf_checker u_sdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_dma_request_a  (o_out.dma_request_a),
    .i_dma_request_b  (o_out.dma_request_b),
    .i_sample_a       (o_out.sample_a),
    .i_sample_a_valid (o_out.sample_a_valid),
    .i_sample_b       (o_out.sample_b),
    .i_sample_b_valid (o_out.sample_b_valid),
    .i_write_dropped  (o_out.write_dropped)
);

// ===== tb/sound_dma_fifo_pair_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sound_dma_fifo_pair_tb
// Self-checking bench for the two-channel sound DMA FIFO pair.
// ---------------------------------------------------------------------------
// A directed pass covers the corner cases first: ticks on an empty FIFO, a full
// FIFO that drops a write, extreme words, unused timers, the unknown kind and
// FIFO clears under a live play buffer. Random traffic follows, in several
// register settings and three idle patterns on the two handshakes. A local
// model of both channels predicts one status per accepted item, and every
// transfer out is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module sound_dma_fifo_pair_tb;
    import sdf_pkg::*;

    // Kind code outside the defined set; the block must leave state untouched.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int LIMIT_CYCLES = 200000;
    // Two register stages inside the block; wait a few more to be safe.
    localparam int DRAIN_CYCLES = 6;
    localparam int SUBPHASES    = 5;

    typedef struct packed {
        logic              req_a;
        logic              req_b;
        logic [BYTE_W-1:0] sample_a;
        logic              sample_a_valid;
        logic [BYTE_W-1:0] sample_b;
        logic              sample_b_valid;
        logic              dropped;
    } t_play_status;

    logic           i_clk;
    logic           i_rst_n;
    logic           cfg_we;
    t_cfg_idx       cfg_idx;
    logic           cfg_data;

    sdf_in_if  in_if ();
    sdf_out_if out_if ();

    sound_dma_fifo_pair uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Local copy of both channels and of the register file.
    logic [WORD_W-1:0] fifo_words [NCHAN][FIFO_WORDS];
    int unsigned       fifo_head  [NCHAN];
    int unsigned       fifo_fill  [NCHAN];
    logic [WORD_W-1:0] play_shift [NCHAN];
    int unsigned       play_left  [NCHAN];
    logic              chan_on    [NCHAN];
    logic              chan_tsel  [NCHAN];

    t_play_status status_due [$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hold every input at a known value from time zero.
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_A_ENABLE;
        cfg_data          = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_WRITE;
        in_if.channel     = 1'b0;
        in_if.timer_index = '0;
        in_if.word_value  = '0;
        out_if.ready      = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Toggle ready at random on the result side, per the current idle pattern.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void clear_model();
        for (int c = 0; c < NCHAN; c++) begin
            for (int w = 0; w < FIFO_WORDS; w++) fifo_words[c][w] = '0;
            fifo_head[c]  = 0;
            fifo_fill[c]  = 0;
            play_shift[c] = '0;
            play_left[c]  = 0;
            chan_on[c]    = 1'b0;
            chan_tsel[c]  = 1'b0;
        end
    endfunction

    // One timer tick on a channel: request, drop a byte, refill if empty.
    function automatic logic tick_play_buffer(int c);
        logic req;
        req = (fifo_fill[c] <= LOW_WATER);
        if (play_left[c] != 0) begin
            play_shift[c] = play_shift[c] >> BYTE_W;
            play_left[c]--;
        end
        if (play_left[c] == 0 && fifo_fill[c] > 0) begin
            play_shift[c] = fifo_words[c][fifo_head[c]];
            play_left[c]  = PLAY_BYTES;
            fifo_head[c]  = (fifo_head[c] + 1) % FIFO_WORDS;
            fifo_fill[c]--;
        end
        return req;
    endfunction

    // Advance the local channels by one item and return the status it yields.
    function automatic t_play_status advance_dma_model(logic [KIND_W-1:0] kind, logic ch,
                                                       logic [TIMER_W-1:0] tmr,
                                                       logic [WORD_W-1:0] word);
        t_play_status st;
        logic         req [NCHAN];
        int           c;
        st     = '0;
        req[0] = 1'b0;
        req[1] = 1'b0;
        c      = ch;
        if (kind == KIND_WRITE) begin
            if (fifo_fill[c] >= FIFO_WORDS) begin
                st.dropped = 1'b1;
            end else begin
                fifo_words[c][(fifo_head[c] + fifo_fill[c]) % FIFO_WORDS] = word;
                fifo_fill[c]++;
            end
        end else if (kind == KIND_TICK) begin
            // A 1-bit select never matches timers 2 and 3.
            for (int i = 0; i < NCHAN; i++) begin
                if (chan_on[i] && {1'b0, chan_tsel[i]} == tmr) req[i] = tick_play_buffer(i);
            end
        end else if (kind == KIND_CLEAR) begin
            // Empty the FIFO; the read pointer and play buffer stay put.
            fifo_fill[c] = 0;
        end
        st.req_a          = req[CH_A];
        st.req_b          = req[CH_B];
        st.sample_a_valid = (play_left[CH_A] != 0);
        st.sample_a       = st.sample_a_valid ? play_shift[CH_A][BYTE_W-1:0] : '0;
        st.sample_b_valid = (play_left[CH_B] != 0);
        st.sample_b       = st.sample_b_valid ? play_shift[CH_B][BYTE_W-1:0] : '0;
        return st;
    endfunction

    task automatic report_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_play_status want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (status_due.size() == 0) begin
                $display("%0t: result transfer with no prediction pending", $time);
                fail_count++;
            end else begin
                want = status_due.pop_front();
                report_field("dma_request_a", want.req_a, out_if.dma_request_a);
                report_field("dma_request_b", want.req_b, out_if.dma_request_b);
                report_field("sample_a", want.sample_a, out_if.sample_a);
                report_field("sample_a_valid", want.sample_a_valid, out_if.sample_a_valid);
                report_field("sample_b", want.sample_b, out_if.sample_b);
                report_field("sample_b_valid", want.sample_b_valid, out_if.sample_b_valid);
                report_field("write_dropped", want.dropped, out_if.write_dropped);
            end
        end
    end

    // Present one item and hold it until the transfer in; enter and leave at
    // a falling edge. Valid stays high for a back-to-back follower.
    task automatic send_item(logic [KIND_W-1:0] kind, logic ch, logic [TIMER_W-1:0] tmr,
                             logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.channel     <= ch;
        in_if.timer_index <= tmr;
        in_if.word_value  <= word;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        status_due.push_back(advance_dma_model(kind, ch, tmr, word));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all four registers, one per cycle; only call while idle.
    task automatic apply_config(logic a_on, logic b_on, logic a_tsel, logic b_tsel);
        t_cfg_idx idx_list [4];
        logic     val_list [4];
        idx_list = '{CFG_A_ENABLE, CFG_B_ENABLE, CFG_A_TIMER, CFG_B_TIMER};
        val_list = '{a_on, b_on, a_tsel, b_tsel};
        for (int r = 0; r < 4; r++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[r];
            cfg_data <= val_list[r];
            @(negedge i_clk);
        end
        cfg_we       <= 1'b0;
        chan_on[0]   = a_on;
        chan_on[1]   = b_on;
        chan_tsel[0] = a_tsel;
        chan_tsel[1] = b_tsel;
        @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        wait_idle();
        apply_config(1'b1, 1'b1, 1'b0, 1'b1);
        // Tick on the empty FIFO of A: request, nothing to unpack.
        send_item(KIND_TICK, 1'b0, 2'd0, '0);
        // Fill A past the top; the ninth write is dropped.
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'h0000_0000);
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'h8040_2010);
        for (int i = 0; i < 5; i++) send_item(KIND_WRITE, 1'b0, 2'd0, $urandom);
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'hDEAD_BEEF);
        // Unpack on a full FIFO: no request.
        send_item(KIND_TICK, 1'b0, 2'd0, '0);
        send_item(KIND_WRITE, 1'b1, 2'd0, 32'h1234_5678);
        send_item(KIND_TICK, 1'b1, 2'd1, '0);
        // Timers without a select, then the unknown kind.
        send_item(KIND_TICK, 1'b0, 2'd2, $urandom);
        send_item(KIND_TICK, 1'b1, 2'd3, $urandom);
        send_item(KIND_UNUSED, 1'b1, 2'd1, $urandom);
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'h5A5A_A5A5);
        // Clear A under a live play buffer, then keep ticking it.
        send_item(KIND_CLEAR, 1'b0, 2'd0, '0);
        send_item(KIND_TICK, 1'b0, 2'd0, '0);
        send_item(KIND_CLEAR, 1'b1, 2'd1, '0);
        send_item(KIND_WRITE, 1'b0, 2'd0, 32'hA5A5_A5A5);
        for (int i = 0; i < 4; i++) send_item(KIND_TICK, 1'b0, 2'd0, '0);
    endtask

    // Random traffic in several register settings; write weight varies so
    // both the low-water mark and the full FIFO are reached.
    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
        int               write_pct;
        int               roll;
        int               pick;
        logic             ch;
        logic [TIMER_W-1:0] tmr;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int p = 0; p < SUBPHASES; p++) begin
            wait_idle();
            unique case (p)
                0: begin
                    apply_config(1'b1, 1'b1, 1'b0, 1'b1);
                end
                1: begin
                    apply_config(1'b1, 1'b1, 1'b1, 1'b1);
                end
                2: begin
                    apply_config(1'b0, 1'b0, 1'b0, 1'b0);
                end
                default: begin
                    apply_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            endcase
            write_pct = $urandom_range(20, 55);
            for (int n = 0; n < n_items / SUBPHASES; n++) begin
                roll = $urandom_range(99);
                ch   = 1'($urandom_range(1));
                tmr  = TIMER_W'($urandom_range(3));
                if (roll < write_pct) begin
                    send_item(KIND_WRITE, ch, tmr, $urandom);
                end else if (roll < 88) begin
                    // Mostly aim the tick at a timer some channel listens to.
                    pick = $urandom_range(1);
                    if ($urandom_range(99) < 85) tmr = {1'b0, chan_tsel[pick]};
                    send_item(KIND_TICK, ch, tmr, $urandom);
                end else if (roll < 95) begin
                    send_item(KIND_CLEAR, ch, tmr, $urandom);
                end else begin
                    send_item(KIND_UNUSED, ch, tmr, $urandom);
                end
            end
        end
    endtask

    initial begin
        clear_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 60;
        test_directed_cases();
        test_random_traffic(9, 60, 250);
        test_random_traffic(60, 9, 250);
        test_random_traffic(0, 0, 250);
        wait_idle();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
